/* hdl/rik_pkg.sv */
// Package for the range-insert k-th largest core: sizes, memory word,
// request and status structs, sequencer states and saturation helpers.
// No dependencies.
package rik_pkg;

    // Tree sizes.
    localparam int MAX_SIZE    = 64;
    localparam int INNER_NODES = 4 * MAX_SIZE;
    localparam int OUTER_NODES = 4 * (MAX_SIZE + 1);
    localparam int MEM_DEPTH   = OUTER_NODES * INNER_NODES;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);

    // Field widths.
    localparam int VAL_W  = 7;
    localparam int SUM_W  = 40;
    localparam int LAZY_W = 32;
    localparam int NODE_W = $clog2(INNER_NODES) + 1;
    localparam int OUT_W  = $clog2(OUTER_NODES) + 2;

    // Traversal stack.
    localparam int STACK_DEPTH = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH) + 1;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [LAZY_W-1:0] LAZY_MAX = {LAZY_W{1'b1}};

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [LAZY_W-1:0] lazy;
    } word_t;

    typedef struct packed {
        logic              post;
        logic [NODE_W-1:0] node;
        logic [VAL_W-1:0]  lo;
        logic [VAL_W-1:0]  hi;
        logic [VAL_W-1:0]  st;
        logic [VAL_W-1:0]  ed;
    } frame_t;

    // Request after clamping, as the engine takes it.
    typedef struct packed {
        logic             op;
        logic [VAL_W-1:0] size;
        logic [VAL_W-1:0] left;
        logic [VAL_W-1:0] right;
        logic [VAL_W-1:0] value;
        logic             empty;
        logic [SUM_W-1:0] k;
    } cmd_t;

    typedef struct packed {
        logic             busy;
        logic             result_valid;
        logic [VAL_W-1:0] kth_value;
    } stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OUTER,
        ST_POP,
        ST_EVAL,
        ST_FULL,
        ST_QLAZY,
        ST_PUSHR,
        ST_PUSHL,
        ST_POST1,
        ST_POST2,
        ST_POST3,
        ST_AFTER_ADD,
        ST_DECIDE,
        ST_DONE
    } state_t;

    // Saturate a grown count back to the sum width.
    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W+1:0] x);
        logic [SUM_W-1:0] r;
        if (x > {2'b00, SUM_MAX}) r = SUM_MAX;
        else r = x[SUM_W-1:0];
        return r;
    endfunction

endpackage

/* hdl/rik_engine.sv */
// Sequencer for the nested segment trees: node memory, traversal stack,
// clearing pass and the outer value-tree descent.
// Depends on rik_pkg.
module rik_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rik_pkg::cmd_t cmd,
    output rik_pkg::stat_t stat
);
    import rik_pkg::*;

    // Node memory, one word per (value node, position node) pair.
    word_t             mem [0:MEM_DEPTH-1];
    word_t             rdata_reg;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    word_t             mem_wdata;

    // Control state.
    state_t            state_reg, state_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              res_valid_reg, res_valid_next;

    // Payload state.
    frame_t            stack_reg [0:STACK_DEPTH-1];
    frame_t            cur_reg, cur_next;
    cmd_t              cmd_reg, cmd_next;
    logic [VAL_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [OUT_W-1:0]  u_reg, u_next, base_reg, base_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [SUM_W-1:0]  k_reg, k_next;
    logic [LAZY_W-1:0] lazy_reg, lazy_next;
    logic [SUM_W-1:0]  prod_reg, prod_next;
    logic [SUM_W-1:0]  suml_reg, suml_next;
    logic [VAL_W-1:0]  res_reg, res_next;

    logic              push_en;
    frame_t            push_frame;

    // Inner node geometry.
    logic [VAL_W-1:0]  imid;
    logic [VAL_W:0]    ilen, qlen;
    logic              full_cover, node_ok, kids_ok;
    logic [ADDR_W-1:0] row_base, cur_addr, kidl_addr, kidr_addr;
    frame_t            left_f, right_f, root_f, post_f;

    // Outer descent helpers.
    logic [VAL_W-1:0]  omid;
    logic [OUT_W-1:0]  child;
    logic [SP_W-1:0]   sp_dec;

    always_comb
    begin
        imid       = VAL_W'(({1'b0, cur_reg.lo} + {1'b0, cur_reg.hi}) >> 1);
        ilen       = {1'b0, cur_reg.hi} - {1'b0, cur_reg.lo} + 1'b1;
        qlen       = {1'b0, cur_reg.ed} - {1'b0, cur_reg.st} + 1'b1;
        full_cover = (cur_reg.st == cur_reg.lo) && (cur_reg.ed == cur_reg.hi);
        node_ok    = cur_reg.node < NODE_W'(INNER_NODES);
        kids_ok    = cur_reg.node < NODE_W'(INNER_NODES / 2);
        row_base   = ADDR_W'(base_reg) * ADDR_W'(INNER_NODES);
        cur_addr   = row_base + ADDR_W'(cur_reg.node);
        kidl_addr  = row_base + ADDR_W'({cur_reg.node, 1'b0});
        kidr_addr  = row_base + ADDR_W'({cur_reg.node, 1'b1});

        left_f      = cur_reg;
        left_f.post = 1'b0;
        left_f.node = {cur_reg.node[NODE_W-2:0], 1'b0};
        left_f.hi   = imid;
        left_f.ed   = (cur_reg.ed < imid) ? cur_reg.ed : imid;

        right_f      = cur_reg;
        right_f.post = 1'b0;
        right_f.node = {cur_reg.node[NODE_W-2:0], 1'b1};
        right_f.lo   = imid + 1'b1;
        right_f.st   = (cur_reg.st > imid + 1'b1) ? cur_reg.st : imid + 1'b1;

        post_f      = cur_reg;
        post_f.post = 1'b1;

        root_f.post = 1'b0;
        root_f.node = NODE_W'(1);
        root_f.lo   = VAL_W'(1);
        root_f.hi   = cmd_reg.size;
        root_f.st   = cmd_reg.left;
        root_f.ed   = cmd_reg.right;

        omid   = VAL_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
        child  = {u_reg[OUT_W-2:0], 1'b1};
        sp_dec = sp_reg - 1'b1;
    end

    // Next state and memory control.
    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        clr_next       = clr_reg;
        res_valid_next = 1'b0;
        cur_next       = cur_reg;
        cmd_next       = cmd_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        u_next         = u_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        lazy_next      = lazy_reg;
        prod_next      = prod_reg;
        suml_next      = suml_reg;
        res_next       = res_reg;
        push_en        = 1'b0;
        push_frame     = root_f;
        mem_re         = 1'b0;
        mem_raddr      = cur_addr;
        mem_we         = 1'b0;
        mem_waddr      = cur_addr;
        mem_wdata      = rdata_reg;

        case (state_reg)
            // Zero the node memory one word a cycle.
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == ADDR_W'(MEM_DEPTH - 1)) state_next = ST_IDLE;
                else clr_next = clr_reg + 1'b1;
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    k_next   = cmd.k;
                    lo_next  = '0;
                    hi_next  = cmd.size;
                    u_next   = OUT_W'(1);
                    if (cmd.op == OP_INSERT && cmd.empty) state_next = ST_DONE;
                    else state_next = ST_OUTER;
                end
            end

            // Start the position-tree walk for the current value node, or for a query its upper child.
            ST_OUTER:
            begin
                acc_next = '0;
                if (cmd_reg.op == OP_INSERT)
                begin
                    if (u_reg >= OUT_W'(OUTER_NODES)) state_next = ST_DONE;
                    else
                    begin
                        base_next  = u_reg;
                        push_en    = 1'b1;
                        sp_next    = sp_reg + 1'b1;
                        state_next = ST_POP;
                    end
                end
                else if (cmd_reg.empty || child >= OUT_W'(OUTER_NODES))
                    state_next = ST_DECIDE;
                else
                begin
                    base_next  = child;
                    push_en    = 1'b1;
                    sp_next    = sp_reg + 1'b1;
                    state_next = ST_POP;
                end
            end

            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    if (cmd_reg.op == OP_INSERT) state_next = ST_AFTER_ADD;
                    else state_next = ST_DECIDE;
                end
                else
                begin
                    cur_next   = stack_reg[sp_dec[SP_W-2:0]];
                    sp_next    = sp_dec;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                if (!node_ok) state_next = ST_POP;
                else if (cur_reg.post)
                begin
                    mem_re     = 1'b1;
                    state_next = ST_POST1;
                end
                else if (full_cover)
                begin
                    mem_re     = 1'b1;
                    state_next = ST_FULL;
                end
                else if (cmd_reg.op == OP_INSERT)
                begin
                    push_en    = 1'b1;
                    push_frame = post_f;
                    sp_next    = sp_reg + 1'b1;
                    state_next = ST_PUSHR;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_QLAZY;
                end
            end

            // Node fully inside the range.
            ST_FULL:
            begin
                if (cmd_reg.op == OP_INSERT)
                begin
                    mem_we         = 1'b1;
                    mem_wdata.sum  = sat_sum({2'b00, rdata_reg.sum} + (SUM_W + 2)'(ilen));
                    mem_wdata.lazy = (rdata_reg.lazy < LAZY_MAX) ?
                                     rdata_reg.lazy + 1'b1 : rdata_reg.lazy;
                end
                else
                    acc_next = sat_sum({2'b00, acc_reg} + {2'b00, rdata_reg.sum});
                state_next = ST_POP;
            end

            // Partial query node adds its own lazy count over the overlap.
            ST_QLAZY:
            begin
                acc_next = sat_sum({2'b00, acc_reg} +
                           (SUM_W + 2)'(rdata_reg.lazy) * (SUM_W + 2)'(qlen));
                state_next = ST_PUSHR;
            end

            ST_PUSHR:
            begin
                if (cur_reg.ed > imid)
                begin
                    push_en    = 1'b1;
                    push_frame = right_f;
                    sp_next    = sp_reg + 1'b1;
                end
                state_next = ST_PUSHL;
            end

            ST_PUSHL:
            begin
                if (cur_reg.st <= imid)
                begin
                    push_en    = 1'b1;
                    push_frame = left_f;
                    sp_next    = sp_reg + 1'b1;
                end
                state_next = ST_POP;
            end

            // Rebuild an insert node's sum from its children and its own lazy count.
            ST_POST1:
            begin
                lazy_next  = rdata_reg.lazy;
                prod_next  = SUM_W'(rdata_reg.lazy) * SUM_W'(ilen);
                mem_re     = kids_ok;
                mem_raddr  = kidl_addr;
                state_next = ST_POST2;
            end

            ST_POST2:
            begin
                suml_next  = kids_ok ? rdata_reg.sum : '0;
                mem_re     = kids_ok;
                mem_raddr  = kidr_addr;
                state_next = ST_POST3;
            end

            ST_POST3:
            begin
                mem_we         = 1'b1;
                mem_wdata.sum  = sat_sum({2'b00, suml_reg} + {2'b00, prod_reg} +
                                 (kids_ok ? {2'b00, rdata_reg.sum} : '0));
                mem_wdata.lazy = lazy_reg;
                state_next     = ST_POP;
            end

            // Step down the value tree toward the inserted value.
            ST_AFTER_ADD:
            begin
                if (lo_reg == hi_reg) state_next = ST_DONE;
                else
                begin
                    if (cmd_reg.value <= omid)
                    begin
                        hi_next = omid;
                        u_next  = {u_reg[OUT_W-2:0], 1'b0};
                    end
                    else
                    begin
                        lo_next = omid + 1'b1;
                        u_next  = child;
                    end
                    state_next = ST_OUTER;
                end
            end

            // Choose the half that holds the k-th largest copy.
            ST_DECIDE:
            begin
                if (k_reg <= acc_reg)
                begin
                    lo_next = omid + 1'b1;
                    u_next  = child;
                end
                else
                begin
                    hi_next = omid;
                    u_next  = {u_reg[OUT_W-2:0], 1'b0};
                    k_next  = k_reg - acc_reg;
                end
                if (lo_next < hi_next) state_next = ST_OUTER;
                else
                begin
                    res_next       = lo_next;
                    res_valid_next = 1'b1;
                    state_next     = ST_DONE;
                end
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sp_reg        <= '0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers and traversal stack.
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        cmd_reg  <= cmd_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        u_reg    <= u_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        k_reg    <= k_next;
        lazy_reg <= lazy_next;
        prod_reg <= prod_next;
        suml_reg <= suml_next;
        res_reg  <= res_next;
        if (push_en) stack_reg[sp_reg[SP_W-2:0]] <= push_frame;
    end

    // Node memory ports.
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) rdata_reg <= mem[mem_raddr];
    end

    assign stat.busy         = (state_reg != ST_IDLE);
    assign stat.result_valid = res_valid_reg;
    assign stat.kth_value    = res_reg;

endmodule

/* hdl/range_insert_kth_largest_core.sv */
// Range insert / range k-th largest core. After reset a clearing pass zeroes
// the 66560-word node memory, one word a cycle, with busy high throughout.
// One request at a time: position-tree nodes are visited one by one through
// the node memory, for up to 8 value levels per request. A query result is
// strobed on result_valid for one cycle; the receiver cannot stall.
module range_insert_kth_largest_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         opcode,
    input  logic [rik_pkg::VAL_W-1:0]    range_left,
    input  logic [rik_pkg::VAL_W-1:0]    range_right,
    input  logic [rik_pkg::VAL_W-1:0]    insert_value,
    input  logic [rik_pkg::SUM_W-1:0]    rank,
    output logic                         result_valid,
    output logic [rik_pkg::VAL_W-1:0]    kth_value,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import rik_pkg::*;

    logic [VAL_W-1:0] active_size_reg, active_size_next;
    logic             cfg_write;
    logic [VAL_W-1:0] size_c, left_c, right_c;
    cmd_t             cmd;
    stat_t            stat;

    // Register interface: one register, decoded at byte addresses 0 to 3 (paddr[2] low).
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {{(32 - VAL_W){1'b0}}, active_size_reg} : '0;

    always_comb
    begin
        active_size_next = active_size_reg;
        if (cfg_write) active_size_next = pwdata[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) active_size_reg <= VAL_W'(MAX_SIZE);
        else active_size_reg <= active_size_next;
    end

    // Clamp the size, the request range and the insert value.
    always_comb
    begin
        if (active_size_reg == '0) size_c = VAL_W'(1);
        else if (active_size_reg > VAL_W'(MAX_SIZE)) size_c = VAL_W'(MAX_SIZE);
        else size_c = active_size_reg;
        left_c  = (range_left == '0) ? VAL_W'(1) : range_left;
        right_c = (range_right > size_c) ? size_c : range_right;

        cmd.op    = opcode;
        cmd.size  = size_c;
        cmd.left  = left_c;
        cmd.right = right_c;
        cmd.value = (insert_value > size_c) ? size_c : insert_value;
        cmd.empty = left_c > right_c;
        cmd.k     = rank;
    end

    rik_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !stat.busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign busy         = stat.busy;
    assign result_valid = stat.result_valid;
    assign kth_value    = stat.kth_value;

`ifndef NO_ASSERTIONS
    // An accepted request always occupies the engine for the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not make the core busy");

    // A result is only shown while the request is still in flight.
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside a request");

    // Results are single-cycle strobes.
    a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe lasted more than one cycle");

    // The answer never exceeds the largest value.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> kth_value <= VAL_W'(MAX_SIZE))
        else $error("result value out of range");
`endif

endmodule

/* tb/rik_checker.sv */
// Checker for the range-insert k-th largest core: watches the request, result
// and configuration channels, predicts query answers and compares them.
// Depends on rik_pkg for sizes, widths and opcodes.
`timescale 1ns / 1ps

module rik_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      opcode,
    input  logic [rik_pkg::VAL_W-1:0] range_left,
    input  logic [rik_pkg::VAL_W-1:0] range_right,
    input  logic [rik_pkg::VAL_W-1:0] insert_value,
    input  logic [rik_pkg::SUM_W-1:0] rank,
    input  logic                      result_valid,
    input  logic [rik_pkg::VAL_W-1:0] kth_value,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    input  logic                      pready,
    output int                        fail_count,
    output int                        pending
);
    import rik_pkg::*;

    localparam int unsigned INNER = INNER_NODES;
    localparam int unsigned OUTER = OUTER_NODES;
    localparam logic [2:0] ADDR_SIZE = 3'd0;
    localparam logic [63:0] CNT_MAX = 64'hFF_FFFF_FFFF;
    localparam logic [31:0] LZ_MAX = 32'hFFFF_FFFF;

    logic [SUM_W-1:0]  cnt_sum  [MEM_DEPTH];
    logic [LAZY_W-1:0] cnt_lazy [MEM_DEPTH];
    logic [VAL_W-1:0]  size_reg;
    logic [VAL_W-1:0]  answers [$];

    function automatic logic [63:0] sat_cnt(input logic [63:0] x);
        return (x > CNT_MAX) ? CNT_MAX : x;
    endfunction

    // Add one copy to every position of [st, ed] within a position tree.
    function automatic void pos_add(input int unsigned base, input int unsigned node,
                                    input int unsigned lo, input int unsigned hi,
                                    input int unsigned st, input int unsigned ed);
        int unsigned mid;
        int unsigned idx;
        logic [63:0] s;
        if (node >= INNER) return;
        idx = base + node;
        if (st == lo && ed == hi) begin
            cnt_sum[idx] = SUM_W'(sat_cnt({24'd0, cnt_sum[idx]} + 64'(hi - lo + 1)));
            if (cnt_lazy[idx] < LZ_MAX) cnt_lazy[idx] = cnt_lazy[idx] + 32'd1;
            return;
        end
        mid = (lo + hi) >> 1;
        if (st <= mid) pos_add(base, node * 2, lo, mid, st, (ed < mid) ? ed : mid);
        if (ed > mid) pos_add(base, node * 2 + 1, mid + 1, hi,
                              (st > mid + 1) ? st : mid + 1, ed);
        s = 0;
        if (node * 2 + 1 < INNER)
            s = sat_cnt({24'd0, cnt_sum[base + node * 2]}
                        + {24'd0, cnt_sum[base + node * 2 + 1]});
        cnt_sum[idx] = SUM_W'(sat_cnt(s + 64'(cnt_lazy[idx]) * 64'(hi - lo + 1)));
    endfunction

    // Count the copies held in [st, ed] of a position tree.
    function automatic logic [63:0] pos_count(input int unsigned base,
                                              input int unsigned node,
                                              input int unsigned lo, input int unsigned hi,
                                              input int unsigned st, input int unsigned ed);
        int unsigned mid;
        int unsigned idx;
        logic [63:0] acc;
        if (node >= INNER) return 0;
        idx = base + node;
        if (st == lo && ed == hi) return {24'd0, cnt_sum[idx]};
        mid = (lo + hi) >> 1;
        acc = sat_cnt(64'(cnt_lazy[idx]) * 64'(ed - st + 1));
        if (st <= mid)
            acc = sat_cnt(acc + pos_count(base, node * 2, lo, mid, st,
                                          (ed < mid) ? ed : mid));
        if (ed > mid)
            acc = sat_cnt(acc + pos_count(base, node * 2 + 1, mid + 1, hi,
                                          (st > mid + 1) ? st : mid + 1, ed));
        return acc;
    endfunction

    // Apply one request to the store; queries push their answer.
    function automatic void apply_request(input logic op, input logic [VAL_W-1:0] l_in,
                                          input logic [VAL_W-1:0] r_in,
                                          input logic [VAL_W-1:0] v_in,
                                          input logic [SUM_W-1:0] k_in);
        int unsigned n, left, right, value, lo, hi, u, mid, child;
        logic [63:0] k, cnt;
        logic empty;
        n = 32'(size_reg);
        left = 32'(l_in);
        right = 32'(r_in);
        value = 32'(v_in);
        k = {24'd0, k_in};
        if (n < 1) n = 1;
        if (n > MAX_SIZE) n = MAX_SIZE;
        if (left < 1) left = 1;
        if (right > n) right = n;
        empty = left > right;
        lo = 0;
        hi = n;
        u = 1;
        if (op == OP_INSERT) begin
            if (value > n) value = n;
            if (empty) return;
            forever begin
                if (u >= OUTER) return;
                pos_add(u * INNER, 1, 1, n, left, right);
                if (lo == hi) return;
                mid = (lo + hi) >> 1;
                if (value <= mid) begin
                    hi = mid;
                    u = u * 2;
                end
                else begin
                    lo = mid + 1;
                    u = u * 2 + 1;
                end
            end
        end
        do begin
            child = u * 2 + 1;
            cnt = 0;
            if (!empty && child < OUTER)
                cnt = pos_count(child * INNER, 1, 1, n, left, right);
            mid = (lo + hi) >> 1;
            if (k <= cnt) begin
                lo = mid + 1;
                u = child;
            end
            else begin
                hi = mid;
                u = u * 2;
                k = k - cnt;
            end
        end while (lo < hi);
        answers.push_back(VAL_W'(lo));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fail_count = fail_count + 1;
    endtask

    assign pending = answers.size();

    // Watch the channels; reset clears the store once.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < MEM_DEPTH; i++) begin
                cnt_sum[i] = '0;
                cnt_lazy[i] = '0;
            end
            size_reg = 7'd64;
            fail_count = 0;
            answers.delete();
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_SIZE)
                size_reg = pwdata[VAL_W-1:0];
            if (result_valid) begin
                if (answers.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", kth_value));
                else begin
                    if (kth_value !== answers[0])
                        report_mismatch($sformatf("kth_value %0d, expected %0d",
                                                  kth_value, answers[0]));
                    void'(answers.pop_front());
                end
            end
            if (start && !busy)
                apply_request(opcode, range_left, range_right, insert_value, rank);
        end
    end

endmodule

/* tb/tb_range_insert_kth_largest_core.sv */
// Testbench top for the range-insert k-th largest core: drives requests and
// size writes, and gives the verdict. Depends on rik_pkg and rik_checker.
`timescale 1ns / 1ps

module tb_range_insert_kth_largest_core;
    import rik_pkg::*;

    localparam int CYCLE_LIMIT = 8000000;
    localparam int SEGMENTS = 8;
    localparam int SEG_ITEMS = 136;
    localparam logic [2:0] ADDR_SIZE = 3'd0;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic opcode;
    logic [VAL_W-1:0] range_left;
    logic [VAL_W-1:0] range_right;
    logic [VAL_W-1:0] insert_value;
    logic [SUM_W-1:0] rank;
    logic result_valid;
    logic [VAL_W-1:0] kth_value;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    int fail_count;
    int pending;
    int cycles;
    int idle_pct;
    int unsigned cur_size;

    range_insert_kth_largest_core dut (.*);

    rik_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run-time guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Issue one request once the core is free, with random sender gaps.
    task automatic send_request(input logic op, input int unsigned l, input int unsigned r,
                                input int unsigned v, input logic [SUM_W-1:0] k);
        while ($urandom_range(99) < idle_pct) @(negedge clk);
        while (busy) @(negedge clk);
        start <= 1'b1;
        opcode <= op;
        range_left <= VAL_W'(l);
        range_right <= VAL_W'(r);
        insert_value <= VAL_W'(v);
        rank <= k;
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Write the size register once the core has drained.
    task automatic write_size(input int unsigned sz);
        while (busy || pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_SIZE;
        pwdata <= 32'(sz);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_size = (sz < 1) ? 1 : ((sz > MAX_SIZE) ? MAX_SIZE : sz);
    endtask

    // Mostly in-range requests; a few with out-of-range fields.
    task automatic random_request();
        int unsigned l, r, v, pick;
        logic op;
        logic [SUM_W-1:0] k;
        op = ($urandom_range(99) < 45) ? OP_INSERT : OP_QUERY;
        if ($urandom_range(99) < 85) begin
            l = $urandom_range(cur_size, 1);
            r = ($urandom_range(1) == 0) ? $urandom_range(cur_size, l)
                                         : ((l + 3 > cur_size) ? cur_size : l + 3);
        end
        else begin
            l = $urandom_range(127);
            r = $urandom_range(127);
        end
        v = ($urandom_range(99) < 90) ? $urandom_range(cur_size) : $urandom_range(127);
        pick = $urandom_range(99);
        if (pick < 70) k = SUM_W'($urandom_range(40, 1));
        else if (pick < 82) k = SUM_W'($urandom_range(600, 1));
        else if (pick < 87) k = '0;
        else k = SUM_W'({$urandom, $urandom});
        send_request(op, l, r, v, k);
    endtask

    initial
    begin
        int seg_sizes [SEGMENTS];
        int seg_idle [4];
        seg_sizes = '{64, 1, 17, 64, 2, 45, 33, 64};
        seg_idle = '{0, 58, 0, 18};
        cycles = 0;
        idle_pct = 0;
        cur_size = 64;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_INSERT;
        range_left = '0;
        range_right = '0;
        insert_value = '0;
        rank = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: full range, extremes, clamped fields, empty ranges, rank edges.
        send_request(OP_INSERT, 1, 64, 0, 1);
        send_request(OP_INSERT, 1, 1, 64, 1);
        send_request(OP_INSERT, 64, 64, 127, 1);
        send_request(OP_INSERT, 0, 127, 30, 1);
        send_request(OP_INSERT, 5, 3, 50, 1);
        send_request(OP_QUERY, 1, 64, 0, 1);
        send_request(OP_QUERY, 1, 64, 0, 2);
        send_request(OP_QUERY, 1, 64, 0, 0);
        send_request(OP_QUERY, 1, 64, 0, 40'hFF_FFFF_FFFF);
        send_request(OP_QUERY, 64, 64, 0, 1);
        send_request(OP_QUERY, 0, 127, 0, 130);
        send_request(OP_QUERY, 0, 127, 0, 131);
        send_request(OP_QUERY, 9, 4, 0, 1);
        send_request(OP_QUERY, 1, 1, 0, 2);
        write_size(0);
        send_request(OP_INSERT, 1, 1, 127, 1);
        send_request(OP_QUERY, 1, 1, 0, 1);
        send_request(OP_QUERY, 0, 127, 0, 0);
        write_size(100);
        send_request(OP_QUERY, 1, 64, 0, 3);
        write_size(127);
        send_request(OP_QUERY, 2, 63, 0, 1);

        // Random segments with a range of sizes and sender idling.
        for (int s = 0; s < SEGMENTS; s++) begin
            write_size(seg_sizes[s]);
            idle_pct = seg_idle[s % 4];
            for (int i = 0; i < SEG_ITEMS; i++)
                random_request();
        end
        idle_pct = 0;

        while (busy || pending != 0) @(negedge clk);
        repeat (500) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
